>>> rtl/pva_pkg.sv
// Shared types and constants for the polyphonic voice allocator.
`default_nettype none

package pva_pkg;

  localparam int OP_W           = 2;
  localparam int NOTE_W         = 7;
  localparam int MASK_W         = 8;
  localparam int VOICE_W        = 3;
  localparam int MAX_VOICES     = 8;
  localparam int DEFAULT_VOICES = 8;

  typedef enum logic [OP_W-1:0] {
    OP_NOTE_ON     = 2'd0,
    OP_NOTE_OFF    = 2'd1,
    OP_RELEASE_ALL = 2'd2,
    OP_TICK        = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [NOTE_W-1:0] note;
    logic [MASK_W-1:0] busy_mask;
  } in_t;

  typedef struct packed {
    logic               trigger_valid;
    logic [VOICE_W-1:0] trigger_voice;
    logic               was_stolen;
    logic [MASK_W-1:0]  release_mask;
    logic               update_valid;
    logic [VOICE_W-1:0] update_voice;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } pva_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } pva_status_t;

endpackage

`default_nettype wire

>>> rtl/pva_ctrl.sv
// Controller state machine of the voice allocator: load, voice scan, commit.
`default_nettype none

module pva_ctrl
  import pva_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire pva_status_t status,
  output pva_cmd_t         cmd,
  output logic             busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r,  busy_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_SCAN;
      S_SCAN: if (status.scan_last) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign cmd.load   = start && (state_r == S_IDLE);
  assign cmd.step   = (state_r == S_SCAN);
  assign cmd.commit = (state_r == S_FIN);
  assign busy       = busy_r;

endmodule

`default_nettype wire

>>> rtl/pva_datapath.sv
// Datapath of the voice allocator: note store, pointers, scan and result register.
`default_nettype none

module pva_datapath
  import pva_pkg::*;
#(
  parameter int VOICES = DEFAULT_VOICES
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire pva_cmd_t cmd,
  input  wire in_t      in_item,
  output pva_status_t   status,
  output logic          out_valid,
  output out_t          out_item
);

  localparam int NV    = (VOICES < MAX_VOICES) ? VOICES : MAX_VOICES;
  localparam int IDX_W = $clog2(NV);
  localparam logic [MASK_W-1:0] ALL_MASK = MASK_W'((16'd1 << NV) - 16'd1);

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(NV - 1)) ? '0 : p + 1'b1;
  endfunction

  in_t               in_r;
  logic [IDX_W-1:0]  idx_r;
  logic              found_r;
  logic [IDX_W-1:0]  found_v_r;
  logic [MASK_W-1:0] rel_r;
  logic [NOTE_W-1:0] voice_note_r [NV];
  logic [IDX_W-1:0]  steal_r, steal_nxt;
  logic [IDX_W-1:0]  upd_r,   upd_nxt;
  logic              out_valid_r;
  out_t              out_r, res;

  logic [VOICE_W-1:0] idx_ext;
  logic [IDX_W-1:0]   steal_eff, upd_eff, wr_voice;
  logic               note_we;

  assign idx_ext = VOICE_W'(idx_r);
  assign status.scan_last = (idx_r == IDX_W'(NV - 1));

  // A pointer that somehow sits at or above the voice count restarts at voice 0.
  assign steal_eff = ({1'b0, steal_r} >= (IDX_W+1)'(NV)) ? '0 : steal_r;
  assign upd_eff   = ({1'b0, upd_r}   >= (IDX_W+1)'(NV)) ? '0 : upd_r;

  // One voice is examined per scan cycle.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r    <= in_item;
      idx_r   <= '0;
      found_r <= 1'b0;
      rel_r   <= '0;
    end else if (cmd.step) begin
      if (!status.scan_last) idx_r <= idx_r + 1'b1;
      if (!found_r && !in_r.busy_mask[idx_ext]) begin
        found_r   <= 1'b1;
        found_v_r <= idx_r;
      end
      if (voice_note_r[idx_r] == in_r.note) rel_r[idx_ext] <= 1'b1;
    end
  end

  always_comb begin
    res       = '0;
    steal_nxt = steal_eff;
    upd_nxt   = upd_eff;
    note_we   = 1'b0;
    wr_voice  = found_v_r;
    case (in_r.op)
      OP_NOTE_ON: begin
        if (found_r) begin
          wr_voice = found_v_r;
        end else begin
          wr_voice       = steal_eff;
          res.was_stolen = 1'b1;
        end
        steal_nxt         = wrap_next(wr_voice);
        note_we           = 1'b1;
        res.trigger_valid = 1'b1;
        res.trigger_voice = VOICE_W'(wr_voice);
      end
      OP_NOTE_OFF:    res.release_mask = rel_r;
      OP_RELEASE_ALL: res.release_mask = ALL_MASK;
      OP_TICK: begin
        res.update_valid = 1'b1;
        res.update_voice = VOICE_W'(upd_eff);
        upd_nxt          = wrap_next(upd_eff);
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NV; i++) voice_note_r[i] <= '0;
      steal_r     <= '0;
      upd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
      if (cmd.commit) begin
        steal_r <= steal_nxt;
        upd_r   <= upd_nxt;
        if (note_we) voice_note_r[wr_voice] <= in_r.note;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

>>> rtl/poly_voice_allocator_unit.sv
// Top level of the polyphonic voice allocator: controller plus datapath.
`default_nettype none

// The voice engine issues one event at a time on in_item (op, note and its
// current busy mask) by raising start; the event is transferred at the clock
// edge where start is high and busy is low. Busy rises on the next cycle and
// stays high while the allocator walks its voices, one voice per cycle.
// Each event yields exactly one result on out_item, marked by out_valid for a
// single cycle. The receiver has no way to hold a result off, so it must take
// it in that cycle; the block never waits on the output side.
// Let N be the number of voices in use, min(VOICES, 8). After the input
// transfer the controller scans the N voices in S_SCAN, commits in S_FIN and
// the output register then raises out_valid with the result.
// The block takes no new event until the result is shown; busy drops in the
// same cycle in which the result is shown, so the next event may follow at once.
// Only the first eight voices are used when VOICES is larger than eight.
// Synchronous reset (rst_n low) clears the stored notes to note 0, both the
// steal and update pointers to voice 0, and drops busy and out_valid.

module poly_voice_allocator_unit
  import pva_pkg::*;
#(
  parameter int VOICES = DEFAULT_VOICES
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_item,
  output logic      out_valid,
  output out_t      out_item
);

  pva_cmd_t    cmd;
  pva_status_t status;

  pva_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  pva_datapath #(
    .VOICES (VOICES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> rtl/pva_checker.sv
// Port-level checker for the voice allocator and its bind to the top level.
`default_nettype none

module pva_checker
  import pva_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire out_t out_item
);

  // An accepted event always makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an input transfer");

  // A result strobe lasts a single cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held for more than one cycle");

  // A result is shown only when the block is free again.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // A result is never both a trigger and an update step.
  a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.trigger_valid && out_item.update_valid))
    else $error("trigger and update in the same result");

  // Trigger fields are zero for results that are not a trigger.
  a_trigger_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.trigger_valid |->
      (out_item.trigger_voice == '0) && !out_item.was_stolen)
    else $error("trigger fields set without a trigger");

endmodule

bind poly_voice_allocator_unit pva_checker u_pva_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire
